FILE: design/des_rf_pkg.sv
// DES round function package: bit-selection tables, S-box contents and helpers.
// Shared by des_rf_core and des_round_function; depends on nothing else.
package des_rf_pkg;

    localparam int HALF_BITS = 32;
    localparam int KEY_BITS  = 48;
    localparam int GROUPS    = 8;
    localparam int GRP_BITS  = 6;
    localparam int SBOX_BITS = 4;

    typedef logic [HALF_BITS-1:0] half_t;
    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [5:0]           sel_t;
    typedef logic [1:0]           row_t;
    typedef logic [3:0]           col_t;
    typedef logic [SBOX_BITS-1:0] nib_t;

    // E selection table, DES numbering (1 = MSB of the right half)
    localparam sel_t E_SEL [KEY_BITS] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    // P permutation table, DES numbering
    localparam sel_t P_SEL [HALF_BITS] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // S-boxes S1..S8, indexed [box][row][column]
    localparam nib_t SBOX [GROUPS][4][16] = '{
        '{'{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
            4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
          '{4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
            4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8},
          '{4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
            4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0},
          '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
            4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13}},
        '{'{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
            4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
          '{4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
            4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5},
          '{4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
            4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15},
          '{4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
            4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9}},
        '{'{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
            4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
          '{4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
            4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
          '{4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
            4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7},
          '{4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
            4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12}},
        '{'{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
            4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
          '{4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
            4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9},
          '{4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
            4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4},
          '{4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
            4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14}},
        '{'{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
            4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
          '{4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
            4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6},
          '{4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
            4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14},
          '{4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
            4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3}},
        '{'{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
            4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
          '{4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
            4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8},
          '{4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
            4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6},
          '{4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
            4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13}},
        '{'{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
            4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
          '{4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
            4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6},
          '{4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
            4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2},
          '{4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
            4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12}},
        '{'{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
            4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7},
          '{4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
            4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2},
          '{4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
            4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8},
          '{4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
            4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}}
    };

    // Expand the right half to 48 bits (pure wiring)
    function automatic key_t expand(input half_t r);
        key_t x;
        for (int i = 0; i < KEY_BITS; i++) begin
            x[KEY_BITS-1-i] = r[5'(HALF_BITS - int'(E_SEL[i]))];
        end
        return x;
    endfunction

    // Apply the P permutation (pure wiring)
    function automatic half_t permute(input half_t s);
        half_t f;
        for (int i = 0; i < HALF_BITS; i++) begin
            f[HALF_BITS-1-i] = s[5'(HALF_BITS - int'(P_SEL[i]))];
        end
        return f;
    endfunction

endpackage

FILE: design/des_rf_core.sv
// DES f-function datapath: expansion, key mix, eight S-box lookups, P permutation.
// Purely combinational; depends on des_rf_pkg.
module des_rf_core
    import des_rf_pkg::*;
(
    input  half_t right_half,
    input  key_t  round_key,
    output half_t f_value
);

    key_t  mixed;
    half_t sbox_out;

    // Expand and mix in the round key
    assign mixed = expand(right_half) ^ round_key;

    // Look up each 6-bit group: outer bits pick the row, middle bits the column
    always_comb begin
        sbox_out = '0;
        for (int i = 0; i < GROUPS; i++) begin
            logic [GRP_BITS-1:0] grp;
            row_t                row;
            col_t                col;
            grp = mixed[GRP_BITS*(GROUPS-1-i) +: GRP_BITS];
            row = {grp[5], grp[0]};
            col = grp[4:1];
            sbox_out[SBOX_BITS*(GROUPS-1-i) +: SBOX_BITS] = SBOX[i][row][col];
        end
    end

    // Reorder the S-box bits
    assign f_value = permute(sbox_out);

endmodule

FILE: design/des_round_function.sv
// DES round function top level: input register, f-function datapath, result register.
// Depends on des_rf_pkg and des_rf_core.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_right_half[31:0], s_round_key[47:0]
//   m_      | out       | m_valid / m_ready  | m_f_value[31:0]
//
// An accepted transaction loads the input register and moves on into the result
// register, which drives m_valid, once that register is empty or draining; one
// transaction is accepted every cycle while the output is not stalled. The path is
// one expand/XOR, one S-box lookup and wiring between the input and result registers.
// Reset (synchronous, active low) clears both valid flags only.
// A stalled result holds in the result register; the input register keeps
// accepting while it is empty or the result register can drain, so s_ready depends on m_ready.
module des_round_function
    import des_rf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  half_t s_right_half,
    input  key_t  s_round_key,
    output logic  m_valid,
    input  logic  m_ready,
    output half_t m_f_value
);

    logic  in_valid_reg, in_valid_next;
    half_t right_half_reg, right_half_next;
    key_t  round_key_reg, round_key_next;
    logic  out_valid_reg, out_valid_next;
    half_t f_value_reg, f_value_next;
    half_t core_f;
    logic  out_free;
    logic  in_adv;
    logic  s_take;

    des_rf_core u_core (
        .right_half (right_half_reg),
        .round_key  (round_key_reg),
        .f_value    (core_f)
    );

    // Stage handshake: advance when the next stage is empty or draining
    assign out_free = !out_valid_reg || m_ready;
    assign in_adv   = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    // Next values of both stages
    always_comb begin
        in_valid_next   = in_valid_reg;
        right_half_next = right_half_reg;
        round_key_next  = round_key_reg;
        out_valid_next  = out_valid_reg;
        f_value_next    = f_value_reg;
        if (s_take) begin
            right_half_next = s_right_half;
            round_key_next  = s_round_key;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
        if (in_adv) begin
            f_value_next = core_f;
        end
    end

    // Control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload flops
    always_ff @(posedge aclk) begin
        right_half_reg <= right_half_next;
        round_key_reg  <= round_key_next;
        f_value_reg    <= f_value_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_f_value = f_value_reg;

    // An accepted transaction lands in the input register
    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted transaction not captured in input register");

    // An advancing transaction produces a result next cycle
    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_free |=> m_valid)
        else $error("advancing transaction did not reach result register");

    // A blocked input stage holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=>
            in_valid_reg && $stable(right_half_reg) && $stable(round_key_reg))
        else $error("stalled input stage lost its transaction");

    // Result register holds the f-function of the previously held input
    a_out_value: assert property (@(posedge aclk) disable iff (!aresetn)
        in_adv |=> m_f_value == $past(core_f))
        else $error("result register does not match datapath");

endmodule
